// ===== hw/rtl/bcg_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the
// brightness / contrast / gamma pipeline. No dependencies.
package bcg_pkg;

	localparam logic [23:0] GAMMA_ONE = 24'd16384;
	localparam logic [23:0] GAMMA_MIN = 24'd17;
	localparam logic [23:0] GAMMA_MAX = 24'd16384000;
	localparam int LOG_STEPS = 16;
	localparam int EXP_STEPS = 16;
	localparam int DIV_BITS = 35;

	localparam logic [1:0] PLANE_Y   = 2'd0;
	localparam logic [1:0] PLANE_U   = 2'd1;
	localparam logic [1:0] PLANE_V   = 2'd2;
	localparam logic [1:0] PLANE_RAW = 2'd3;

	typedef enum logic [2:0] {
		REG_LUMA_CONTRAST   = 3'd0,
		REG_LUMA_BRIGHTNESS = 3'd1,
		REG_LUMA_GAMMA      = 3'd2,
		REG_CHROMA_SAT      = 3'd3,
		REG_PLANE1_GAMMA    = 3'd4,
		REG_PLANE2_GAMMA    = 3'd5,
		REG_CURVE_MIX       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        luma_contrast;
		logic signed [14:0] luma_brightness;
		logic [23:0]        luma_gamma;
		logic [15:0]        chroma_saturation;
		logic [23:0]        plane1_gamma;
		logic [23:0]        plane2_gamma;
		logic [12:0]        curve_mix;
	} cfg_t;

	// Per-item values that ride alongside the log/div/exp datapath
	typedef struct packed {
		logic signed [22:0] v1;
		logic               zero;
		logic               unit;
		logic               pass;
		logic [7:0]         x;
	} side_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
		logic [63:0] a;
		logic [63:0] r;
		logic [63:0] b;
		a = a_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (a >= r + b) begin
				a = a - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q30 value of 2^(2^-(k+1)), floored square-root chain
	function automatic logic [63:0] exp_root(input int k);
		logic [63:0] r;
		r = isqrt64(64'd2 << 60);
		for (int j = 0; j < k; j++)
			r = isqrt64(r << 30);
		return r;
	endfunction

endpackage

// ===== hw/rtl/bcg_front.sv =====
// Front end: plane selection, Q16 scaling and contrast/brightness affine.
// Three register stages. Depends on bcg_pkg.
module bcg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bcg_pkg::cfg_t       cfg,
	input  logic                in_vld,
	input  logic [7:0]          in_x,
	input  logic [1:0]          in_plane,
	output logic                out_vld,
	output bcg_pkg::side_t      out_side,
	output logic [23:0]         out_g
);

	logic [15:0]        c_sel;
	logic signed [14:0] b_sel;
	logic [23:0]        g_sel;
	logic [23:0]        g_eff;
	logic [16:0]        v0;
	logic signed [17:0] d;

	logic               vld_s1, vld_s2, vld_s3;
	logic signed [17:0] d_s1;
	logic [15:0]        c_s1;
	logic signed [14:0] b_s1, b_s2;
	logic [23:0]        g_s1, g_s2, g_s3;
	logic               unit_s1, unit_s2;
	logic               pass_s1, pass_s2;
	logic [7:0]         x_s1, x_s2;
	logic signed [34:0] prod_s2;
	bcg_pkg::side_t     side_s3;

	logic signed [35:0] r;
	logic signed [22:0] v1;

	always_comb begin
		unique case (in_plane)
			bcg_pkg::PLANE_Y: begin
				c_sel = cfg.luma_contrast;
				b_sel = cfg.luma_brightness;
				g_sel = cfg.luma_gamma;
			end
			bcg_pkg::PLANE_U: begin
				c_sel = cfg.chroma_saturation;
				b_sel = '0;
				g_sel = cfg.plane1_gamma;
			end
			bcg_pkg::PLANE_V: begin
				c_sel = cfg.chroma_saturation;
				b_sel = '0;
				g_sel = cfg.plane2_gamma;
			end
			bcg_pkg::PLANE_RAW: begin
				c_sel = cfg.luma_contrast;
				b_sel = '0;
				g_sel = bcg_pkg::GAMMA_ONE;
			end
		endcase
		g_eff = (g_sel < bcg_pkg::GAMMA_MIN || g_sel > bcg_pkg::GAMMA_MAX)
			? bcg_pkg::GAMMA_ONE : g_sel;
		// x/255 rounded: 257x plus one for the upper half
		v0 = {1'b0, in_x, 8'b0} + {9'b0, in_x} + {16'b0, in_x[7]};
		d = $signed({1'b0, v0}) - 18'sd32768;
	end

	always_comb begin
		r = $signed({prod_s2[34], prod_s2}) + 36'sd2048;
		v1 = $signed(r[34:12]) + 23'sd32768 + $signed({{4{b_s2[14]}}, b_s2, 4'b0000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= d;
			c_s1    <= c_sel;
			b_s1    <= b_sel;
			g_s1    <= g_eff;
			unit_s1 <= (g_eff == bcg_pkg::GAMMA_ONE);
			pass_s1 <= (in_plane == bcg_pkg::PLANE_RAW);
			x_s1    <= in_x;

			prod_s2 <= $signed({1'b0, c_s1}) * d_s1;
			b_s2    <= b_s1;
			g_s2    <= g_s1;
			unit_s2 <= unit_s1;
			pass_s2 <= pass_s1;
			x_s2    <= x_s1;

			side_s3.v1   <= v1;
			side_s3.zero <= v1[22] || (v1 == '0);
			side_s3.unit <= unit_s2;
			side_s3.pass <= pass_s2;
			side_s3.x    <= x_s2;
			g_s3         <= g_s2;
		end
	end

	assign out_vld  = vld_s3;
	assign out_side = side_s3;
	assign out_g    = g_s3;

endmodule

// ===== hw/rtl/bcg_log.sv =====
// Log2 unit: normalise, sixteen squaring stages, then form the Q16 log
// and the scaled dividend magnitude for the gamma divide. Depends on bcg_pkg.
module bcg_log (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  bcg_pkg::side_t  in_side,
	input  logic [23:0]     in_g,
	output logic            out_vld,
	output bcg_pkg::side_t  out_side,
	output logic [23:0]     out_g,
	output logic [34:0]     out_dvd,
	output logic            out_neg
);

	localparam int N = bcg_pkg::LOG_STEPS;

	logic [19:0] u;
	logic [4:0]  m;
	logic [50:0] norm;

	logic           vld_s  [0:N];
	logic [30:0]    x_s    [0:N];
	logic [15:0]    frac_s [0:N];
	logic [4:0]     m_s    [0:N];
	bcg_pkg::side_t side_s [0:N];
	logic [23:0]    g_s    [0:N];

	logic               vld_sa;
	bcg_pkg::side_t     side_sa;
	logic [23:0]        g_sa;
	logic [34:0]        dvd_sa;
	logic               neg_sa;

	logic [5:0]         mm;
	logic signed [21:0] lg;
	logic [21:0]        mag;

	always_comb begin
		u = in_side.v1[19:0];
		m = '0;
		for (int i = 0; i < 20; i++)
			if (u[i])
				m = 5'(i);
		norm = {31'b0, u} << (5'd30 - m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= norm[30:0];
			frac_s[0] <= '0;
			m_s[0]    <= m;
			side_s[0] <= in_side;
			g_s[0]    <= in_g;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] q;
		always_comb begin
			sq = x_s[k] * x_s[k];
			q  = sq[61:30];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= q[31] ? q[31:1] : q[30:0];
				frac_s[k+1] <= {frac_s[k][14:0], q[31]};
				m_s[k+1]    <= m_s[k];
				side_s[k+1] <= side_s[k];
				g_s[k+1]    <= g_s[k];
			end
		end
	end

	always_comb begin
		mm  = {1'b0, m_s[N]} - 6'd16;
		lg  = $signed({mm, frac_s[N]});
		mag = lg[21] ? 22'(-lg) : lg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sa <= 1'b0;
		else if (en)
			vld_sa <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sa <= side_s[N];
			g_sa    <= g_s[N];
			neg_sa  <= lg[21];
			dvd_sa  <= {mag[20:0], 14'b0};
		end
	end

	assign out_vld  = vld_sa;
	assign out_side = side_sa;
	assign out_g    = g_sa;
	assign out_dvd  = dvd_sa;
	assign out_neg  = neg_sa;

endmodule

// ===== hw/rtl/bcg_div.sv =====
// Restoring divider, one quotient bit per stage, then the sign fix-up that
// gives log*gamma_one/gamma truncated toward zero. Depends on bcg_pkg.
module bcg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  bcg_pkg::side_t     in_side,
	input  logic [23:0]        in_g,
	input  logic [34:0]        in_dvd,
	input  logic               in_neg,
	output logic               out_vld,
	output bcg_pkg::side_t     out_side,
	output logic signed [35:0] out_y
);

	localparam int N = bcg_pkg::DIV_BITS;

	logic           vld_s  [0:N];
	logic [23:0]    rem_s  [0:N];
	logic [34:0]    dq_s   [0:N];
	logic           neg_s  [0:N];
	logic [23:0]    g_s    [0:N];
	bcg_pkg::side_t side_s [0:N];

	logic               vld_sy;
	bcg_pkg::side_t     side_sy;
	logic signed [35:0] y_sy;

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign dq_s[0]   = in_dvd;
	assign neg_s[0]  = in_neg;
	assign g_s[0]    = in_g;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_bit
		logic [24:0] trial;
		logic [24:0] diff;
		logic        ge;
		always_comb begin
			trial = {rem_s[k], dq_s[k][34]};
			diff  = trial - {1'b0, g_s[k]};
			ge    = (trial >= {1'b0, g_s[k]});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[23:0] : trial[23:0];
				dq_s[k+1]   <= {dq_s[k][33:0], ge};
				neg_s[k+1]  <= neg_s[k];
				g_s[k+1]    <= g_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sy <= 1'b0;
		else if (en)
			vld_sy <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sy <= side_s[N];
			y_sy    <= neg_s[N] ? -$signed({1'b0, dq_s[N]}) : $signed({1'b0, dq_s[N]});
		end
	end

	assign out_vld  = vld_sy;
	assign out_side = side_sy;
	assign out_y    = y_sy;

endmodule

// ===== hw/rtl/bcg_exp.sv =====
// Exp2 unit: split into integer and fraction, sixteen root-multiply stages,
// then the final scaling shift and unit-gamma bypass. Depends on bcg_pkg.
module bcg_exp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  bcg_pkg::side_t     in_side,
	input  logic signed [35:0] in_y,
	output logic               out_vld,
	output bcg_pkg::side_t     out_side,
	output logic [32:0]        out_p
);

	localparam int N = bcg_pkg::EXP_STEPS;

	logic [19:0] n;

	logic           vld_s   [0:N];
	logic [30:0]    acc_s   [0:N];
	logic [15:0]    f_s     [0:N];
	logic           sat_s   [0:N];
	logic           small_s [0:N];
	logic [5:0]     sh_s    [0:N];
	bcg_pkg::side_t side_s  [0:N];

	logic           vld_sf;
	bcg_pkg::side_t side_sf;
	logic [32:0]    p_sf;
	logic [45:0]    shifted;

	assign n = in_y[35:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0]   <= 31'h4000_0000;
			f_s[0]     <= in_y[15:0];
			sat_s[0]   <= (in_y >= 36'sd1048576);
			small_s[0] <= ($signed(n) < -20'sd17);
			sh_s[0]    <= 6'd29 - n[5:0];
			side_s[0]  <= in_side;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_root
		localparam logic [30:0] ROOT = 31'(bcg_pkg::exp_root(k));
		logic [61:0] prod;
		assign prod = acc_s[k] * ROOT;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k+1]   <= f_s[k][N-1-k] ? prod[60:30] : acc_s[k];
				f_s[k+1]     <= f_s[k];
				sat_s[k+1]   <= sat_s[k];
				small_s[k+1] <= small_s[k];
				sh_s[k+1]    <= sh_s[k];
				side_s[k+1]  <= side_s[k];
			end
		end
	end

	assign shifted = {acc_s[N], 15'b0} >> sh_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sf <= 1'b0;
		else if (en)
			vld_sf <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sf <= side_s[N];
			priority if (side_s[N].unit)
				p_sf <= {10'b0, side_s[N].v1};
			else if (sat_s[N])
				p_sf <= 33'h1_0000_0000;
			else if (small_s[N])
				p_sf <= '0;
			else
				p_sf <= shifted[32:0];
		end
	end

	assign out_vld  = vld_sf;
	assign out_side = side_sf;
	assign out_p    = p_sf;

endmodule

// ===== hw/rtl/bcg_back.sv =====
// Back end: gamma blend products, clamp to 8 bits and a two-entry output
// buffer that sets the pipeline advance. Depends on bcg_pkg.
module bcg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [12:0]     weight,
	input  logic            in_vld,
	input  bcg_pkg::side_t  in_side,
	input  logic [32:0]     in_p,
	output logic            adv,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_data
);

	logic signed [13:0] wa;

	logic               vld_s1;
	logic signed [36:0] m1_s1;
	logic [45:0]        m2_s1;
	logic               pass_s1, zero_s1;
	logic [7:0]         x_s1;

	logic signed [47:0] sum;
	logic [7:0]         res;

	logic [1:0] cnt_q;
	logic [7:0] e0_q, e1_q;
	logic       push, pop;

	assign wa = 14'sd4096 - $signed({1'b0, weight});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s1   <= wa * in_side.v1;
			m2_s1   <= weight * in_p;
			pass_s1 <= in_side.pass;
			zero_s1 <= in_side.zero;
			x_s1    <= in_side.x;
		end
	end

	always_comb begin
		sum = $signed({{11{m1_s1[36]}}, m1_s1}) + $signed({2'b00, m2_s1});
		priority if (pass_s1)
			res = x_s1;
		else if (zero_s1 || sum[47])
			res = '0;
		else if (sum[46:28] != '0)
			res = 8'hFF;
		else
			res = sum[27:20];
	end

	assign adv  = (cnt_q != 2'd2);
	assign push = vld_s1 && adv;
	assign pop  = (cnt_q != 2'd0) && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (push && !pop)
			cnt_q <= cnt_q + 2'd1;
		else if (pop && !push)
			cnt_q <= cnt_q - 2'd1;
	end

	// Land a new item at the head when the buffer is empty or the head leaves now
	always_ff @(posedge clk) begin
		if (push) begin
			if (cnt_q == 2'd0 || pop)
				e0_q <= res;
			else
				e1_q <= res;
		end else if (pop) begin
			e0_q <= e1_q;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = e0_q;

endmodule

// ===== hw/rtl/brightness_contrast_gamma_curve_top.sv =====
// Top level of the brightness / contrast / gamma sample pipeline.
// Instantiates bcg_front, bcg_log, bcg_div, bcg_exp and bcg_back; uses bcg_pkg.

// One 8-bit planar-YUV sample enters per clock while tready is high, with
// its plane number in tuser (0 luma, 1 and 2 chroma, 3 passes the sample
// through untouched). Plane 0 takes luma contrast, brightness and gamma;
// planes 1 and 2 take the chroma saturation as contrast, no brightness and
// their own gamma. The pipeline takes a new item every cycle while tready
// is high and delivers one result per item, in order. Each item passes
// through the affine front end, the chain of 16 squaring stages of the log,
// 35 one-bit divider stages for the gamma divide, the 16 root-multiply
// stages of the exp and the blend. A two-item output buffer decouples the
// sides: while the consumer stalls, items keep entering until the buffer
// holds two; tready drops only then. Write registers only while no items
// are in flight; a write takes effect at the edge where cfg_we is high.
module brightness_contrast_gamma_curve_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] sample_in
	input  logic [1:0]  s_axis_tuser,   // [1:0] plane_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [7:0] sample_out
);

	bcg_pkg::cfg_t cfg_q;

	logic adv;

	logic           f_vld;
	bcg_pkg::side_t f_side;
	logic [23:0]    f_g;

	logic           l_vld;
	bcg_pkg::side_t l_side;
	logic [23:0]    l_g;
	logic [34:0]    l_dvd;
	logic           l_neg;

	logic               d_vld;
	bcg_pkg::side_t     d_side;
	logic signed [35:0] d_y;

	logic           e_vld;
	bcg_pkg::side_t e_side;
	logic [32:0]    e_p;

	// Register file: take the low bits of the write data for each register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.luma_contrast     <= 16'd4096;
			cfg_q.luma_brightness   <= '0;
			cfg_q.luma_gamma        <= bcg_pkg::GAMMA_ONE;
			cfg_q.chroma_saturation <= 16'd4096;
			cfg_q.plane1_gamma      <= bcg_pkg::GAMMA_ONE;
			cfg_q.plane2_gamma      <= bcg_pkg::GAMMA_ONE;
			cfg_q.curve_mix         <= 13'd4096;
		end else if (cfg_we) begin
			unique case (bcg_pkg::reg_idx_t'(cfg_addr))
				bcg_pkg::REG_LUMA_CONTRAST:   cfg_q.luma_contrast <= cfg_data[15:0];
				bcg_pkg::REG_LUMA_BRIGHTNESS: cfg_q.luma_brightness <= $signed(cfg_data[14:0]);
				bcg_pkg::REG_LUMA_GAMMA:      cfg_q.luma_gamma <= cfg_data;
				bcg_pkg::REG_CHROMA_SAT:      cfg_q.chroma_saturation <= cfg_data[15:0];
				bcg_pkg::REG_PLANE1_GAMMA:    cfg_q.plane1_gamma <= cfg_data;
				bcg_pkg::REG_PLANE2_GAMMA:    cfg_q.plane2_gamma <= cfg_data;
				bcg_pkg::REG_CURVE_MIX:       cfg_q.curve_mix <= cfg_data[12:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	// Whole pipeline advances together; the output buffer absorbs stalls
	assign s_axis_tready = adv;

	bcg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.cfg      (cfg_q),
		.in_vld   (s_axis_tvalid),
		.in_x     (s_axis_tdata),
		.in_plane (s_axis_tuser),
		.out_vld  (f_vld),
		.out_side (f_side),
		.out_g    (f_g)
	);

	bcg_log u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (f_vld),
		.in_side  (f_side),
		.in_g     (f_g),
		.out_vld  (l_vld),
		.out_side (l_side),
		.out_g    (l_g),
		.out_dvd  (l_dvd),
		.out_neg  (l_neg)
	);

	bcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (l_vld),
		.in_side  (l_side),
		.in_g     (l_g),
		.in_dvd   (l_dvd),
		.in_neg   (l_neg),
		.out_vld  (d_vld),
		.out_side (d_side),
		.out_y    (d_y)
	);

	bcg_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (d_vld),
		.in_side  (d_side),
		.in_y     (d_y),
		.out_vld  (e_vld),
		.out_side (e_side),
		.out_p    (e_p)
	);

	bcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.weight    (cfg_q.curve_mix),
		.in_vld    (e_vld),
		.in_side   (e_side),
		.in_p      (e_p),
		.adv       (adv),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// Input side only blocks when the output buffer holds results
	a_ready_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with an empty output buffer");

	// A result refused by the consumer stays at the head of the buffer
	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output buffer head changed while stalled");

endmodule

// ===== tb/bcg_checker.sv =====
// Checker for the brightness / contrast / gamma pipeline: watches the config
// port and both streams, predicts each sample and compares. Uses bcg_pkg.
module bcg_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	bcg_pkg::cfg_t shadow;
	logic [7:0] expected_samples[$];
	longint unsigned root_q30[16];

	function automatic longint unsigned int_sqrt(longint unsigned a);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > a)
			b >>= 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint floor_div_pow2(longint a, int n);
		return a >>> n;
	endfunction

	function automatic longint log2_fix(longint v);
		longint unsigned u, x;
		int m;
		longint fr;
		u = v;
		m = 0;
		fr = 0;
		while (m < 62 && (u >> (m + 1)) != 0)
			m++;
		x = (m <= 30) ? (u << (30 - m)) : (u >> (m - 30));
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			fr = fr << 1;
			if (x >= (64'd1 << 31)) begin
				x >>= 1;
				fr |= 1;
			end
		end
		return longint'(m - 16) * 65536 + fr;
	endfunction

	function automatic longint exp2_fix(longint y);
		longint unsigned acc;
		longint n, f;
		acc = 64'd1 << 30;
		if (y >= 16 * 65536)
			return 64'sd1 << 32;
		n = y >>> 16;
		f = y - n * 65536;
		for (int k = 0; k < 16; k++)
			if ((f >> (15 - k)) & 1)
				acc = (acc * root_q30[k]) >> 30;
		if (n >= 0)
			return longint'((acc << n) >> 14);
		if (14 - n > 40)
			return 0;
		return longint'(acc >> (14 - n));
	endfunction

	function automatic logic [7:0] equalise(logic [7:0] x, logic [15:0] c, longint b,
			logic [23:0] g_raw);
		longint v0, v1, p, v2, w;
		logic [23:0] g;
		w = shadow.curve_mix;
		g = g_raw;
		v0 = (longint'(x) * 65536 + 127) / 255;
		v1 = floor_div_pow2(longint'(c) * (v0 - 32768) + 2048, 12) + 32768 + 16 * b;
		if (v1 <= 0)
			return 8'd0;
		if (g < bcg_pkg::GAMMA_MIN || g > bcg_pkg::GAMMA_MAX)
			g = bcg_pkg::GAMMA_ONE;
		if (g == bcg_pkg::GAMMA_ONE)
			p = v1;
		else
			p = exp2_fix(log2_fix(v1) * 16384 / longint'(g));
		v2 = floor_div_pow2((4096 - w) * v1 + w * p, 12);
		if (v2 >= 65536)
			return 8'd255;
		if (v2 < 0)
			return 8'd0;
		return v2[15:8];
	endfunction

	function automatic logic [7:0] predict_sample(logic [7:0] x, logic [1:0] plane);
		case (plane)
			bcg_pkg::PLANE_Y: return equalise(x, shadow.luma_contrast,
				longint'(shadow.luma_brightness), shadow.luma_gamma);
			bcg_pkg::PLANE_U: return equalise(x, shadow.chroma_saturation, 0,
				shadow.plane1_gamma);
			bcg_pkg::PLANE_V: return equalise(x, shadow.chroma_saturation, 0,
				shadow.plane2_gamma);
			default: return x;
		endcase
	endfunction

	initial begin
		root_q30[0] = int_sqrt(64'd2 << 60);
		for (int k = 1; k < 16; k++)
			root_q30[k] = int_sqrt(root_q30[k - 1] << 30);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow.luma_contrast <= 16'd4096;
			shadow.luma_brightness <= '0;
			shadow.luma_gamma <= bcg_pkg::GAMMA_ONE;
			shadow.chroma_saturation <= 16'd4096;
			shadow.plane1_gamma <= bcg_pkg::GAMMA_ONE;
			shadow.plane2_gamma <= bcg_pkg::GAMMA_ONE;
			shadow.curve_mix <= 13'd4096;
			errors <= 0;
			pending <= 0;
			expected_samples.delete();
		end else begin
			if (cfg_we) begin
				case (bcg_pkg::reg_idx_t'(cfg_addr))
					bcg_pkg::REG_LUMA_CONTRAST:   shadow.luma_contrast <= cfg_data[15:0];
					bcg_pkg::REG_LUMA_BRIGHTNESS: shadow.luma_brightness <= cfg_data[14:0];
					bcg_pkg::REG_LUMA_GAMMA:      shadow.luma_gamma <= cfg_data;
					bcg_pkg::REG_CHROMA_SAT:      shadow.chroma_saturation <= cfg_data[15:0];
					bcg_pkg::REG_PLANE1_GAMMA:    shadow.plane1_gamma <= cfg_data;
					bcg_pkg::REG_PLANE2_GAMMA:    shadow.plane2_gamma <= cfg_data;
					bcg_pkg::REG_CURVE_MIX:       shadow.curve_mix <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_samples.push_back(predict_sample(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					$error("sample_out: nothing expected, actual %0d", m_axis_tdata);
					errors <= errors + 1;
				end else if (expected_samples[0] !== m_axis_tdata) begin
					$error("sample_out: expected %0d actual %0d",
						expected_samples[0], m_axis_tdata);
					errors <= errors + 1;
					void'(expected_samples.pop_front());
				end else begin
					void'(expected_samples.pop_front());
				end
			end
			pending <= expected_samples.size();
		end
	end
endmodule

// ===== tb/tb.sv =====
// Testbench top for brightness_contrast_gamma_curve_top: drives samples and
// register writes, stalls the output; depends on bcg_pkg and bcg_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 77;
	localparam int WATCHDOG_CYCLES = 4000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [23:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] sample_in
	logic [1:0]  s_axis_tuser = '0;    // [1:0] plane_index
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // [7:0] sample_out
	int          errors;
	int          pending;
	int          idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	brightness_contrast_gamma_curve_top dut (.*);

	bcg_checker checker_i (.*);

	// Watchdog: count cycles with no handshake on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: hold tready low for a random stretch, then take one item.
	// Some stretches run with no stall at all.
	initial begin
		int gap;
		bit streaming;
		streaming = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 199) == 0)
				streaming = ~streaming;
			gap = streaming ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Raise the write enable with address and data and wait for a clock edge; the caller drops it after the last write
	task automatic write_reg(bcg_pkg::reg_idx_t idx, logic [23:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Drain the pipe before touching registers
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	// Offer one item; idle gaps are drawn unless streaming
	task automatic send_sample(logic [7:0] x, logic [1:0] plane, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= x;
		s_axis_tuser <= plane;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Pick a gamma: sometimes sensible or unit, more often out of range or at the edges
	function automatic logic [23:0] pick_gamma();
		case ($urandom_range(0, 9))
			0: return 24'd0;
			1: return 24'd16;
			2: return 24'd17;
			3: return 24'd16384000;
			4: return 24'(24'd16384001 + $urandom_range(0, 390000));
			5: return 24'hFFFFFF;
			6: return bcg_pkg::GAMMA_ONE;
			default: return 24'($urandom_range(1638, 163840));
		endcase
	endfunction

	task automatic random_settings(bit extreme);
		write_reg(bcg_pkg::REG_LUMA_CONTRAST, extreme ? 24'($urandom_range(0, 1) * 16'hFFFF)
			: 24'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 3)));
		write_reg(bcg_pkg::REG_LUMA_BRIGHTNESS,
			24'(15'($urandom_range(0, 16384) - 8192)));
		write_reg(bcg_pkg::REG_LUMA_GAMMA, pick_gamma());
		write_reg(bcg_pkg::REG_CHROMA_SAT,
			extreme ? 24'hFFFF : 24'($urandom_range(0, 16'hFFFF)));
		write_reg(bcg_pkg::REG_PLANE1_GAMMA, pick_gamma());
		write_reg(bcg_pkg::REG_PLANE2_GAMMA, pick_gamma());
		// weight above one now and then, including the full field
		write_reg(bcg_pkg::REG_CURVE_MIX,
			extreme ? 24'h1FFF : 24'($urandom_range(0, 5000)));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		bit burst;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of sample and every plane at reset settings
		for (int p = 0; p < 4; p++) begin
			send_sample(8'd0, 2'(p), 1'b0);
			send_sample(8'd255, 2'(p), 1'b0);
			send_sample(8'hAA, 2'(p), 1'b1);
			send_sample(8'h55, 2'(p), 1'b1);
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// Extreme gains, brightness and weight; a large gamma and a tiny one
		write_reg(bcg_pkg::REG_LUMA_CONTRAST, 24'hFFFF);
		write_reg(bcg_pkg::REG_LUMA_BRIGHTNESS, 24'(15'sd8192));
		write_reg(bcg_pkg::REG_LUMA_GAMMA, 24'd16384000);
		write_reg(bcg_pkg::REG_CHROMA_SAT, 24'd0);
		write_reg(bcg_pkg::REG_PLANE1_GAMMA, 24'd17);
		write_reg(bcg_pkg::REG_PLANE2_GAMMA, 24'd16);
		write_reg(bcg_pkg::REG_CURVE_MIX, 24'h1FFF);
		cfg_we <= 1'b0;
		for (int p = 0; p < 4; p++) begin
			send_sample(8'd1, 2'(p), 1'b0);
			send_sample(8'd200, 2'(p), 1'b0);
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// Random phases; each ends by draining, so the sender waits for all results
		for (phase = 0; phase < 20; phase++) begin
			random_settings(phase % 5 == 4);
			burst = (phase % 3 == 0);
			for (int i = 0; i < 100; i++)
				send_sample(8'($urandom), 2'($urandom), burst && (i < 60));
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end

		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
